/* rtl/core/gfau_pkg.sv */
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types, constants and field helpers of the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gfau_pkg;

   localparam int ELEM_W       = 16;   // element and exponent width
   localparam int DEG_W        = 5;    // width of a field degree
   localparam int MAX_DEG_DFLT = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DEG_W-1:0] DEGREE_RESET = 5'd8;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_MUL = 2'd1,
      CMD_DIV = 2'd2,
      CMD_POW = 2'd3
   } gfau_cmd_type;

   // One classified request: result = x * base^expo
   typedef struct packed {
      logic [DEG_W-1:0]  m;
      logic [ELEM_W-1:0] x;
      logic [ELEM_W-1:0] base;
      logic [ELEM_W-1:0] expo;
      logic              dz;
   } gfau_op_type;

   typedef struct packed {
      logic [DEG_W-1:0]  m;
      logic [ELEM_W-1:0] x;
      logic [ELEM_W-1:0] base;
      logic [ELEM_W-1:0] r;
      logic [ELEM_W-1:0] expo;
      logic              dz;
   } gfau_stage_type;

   // Low terms of the primitive polynomial of degree m
   function automatic logic [ELEM_W-1:0] poly_low(input logic [DEG_W-1:0] m);
      logic [ELEM_W-1:0] p;
      case (m)
         5'd1:    p = 16'h0001;
         5'd2:    p = 16'h0003;
         5'd3:    p = 16'h0003;
         5'd4:    p = 16'h0003;
         5'd5:    p = 16'h0005;
         5'd6:    p = 16'h0003;
         5'd7:    p = 16'h0009;
         5'd8:    p = 16'h001D;
         5'd9:    p = 16'h0011;
         5'd10:   p = 16'h0009;
         5'd11:   p = 16'h0005;
         5'd12:   p = 16'h0053;
         5'd13:   p = 16'h001B;
         5'd14:   p = 16'h0443;
         5'd15:   p = 16'h0003;
         5'd16:   p = 16'h100B;
         default: p = 16'h0000;
      endcase
      return p;
   endfunction

   // Shift-and-XOR multiply with reduction; operands must be below 2^m
   function automatic logic [ELEM_W-1:0] gf_mul(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b,
                                                input logic [DEG_W-1:0]  m);
      logic [ELEM_W:0] top;
      logic [ELEM_W:0] red;
      logic [ELEM_W:0] r;
      top = (ELEM_W+1)'(1) << m;
      red = top | {1'b0, poly_low(m)};
      r   = '0;
      for (int i = ELEM_W - 1; i >= 0; i--) begin
         r = r << 1;
         if ((r & top) != '0) r = r ^ red;
         if (b[i]) r = r ^ {1'b0, a};
      end
      return r[ELEM_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gf2m_field_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// gf2m_field_arithmetic_unit
// GF(2^m) add, multiply, divide and power, m from 1 to 16.
//
// Requests enter on req_ (cmd in tuser, operands in tdata), results leave on
// rsp_ (result in tdata, divide-by-zero flag in tuser). The degree m is
// written on csr_; 0 acts as 1 and values above MAX_DEGREE saturate. Change it
// only while no request is in flight. Reset sets m to 8 and empties the unit.
// Every request is decoded into x * base^e and runs through a 4-entry queue,
// a 16-stage square-and-multiply pipeline (one exponent bit and two field
// multiplies per stage) and a final multiply into the output register.
// Throughput is one request per cycle while rsp_tready is high; a request
// passes the queue, the stage registers and the output register. While a
// response waits with rsp_tready low the whole pipeline freezes, the queue
// fills and req_tready drops once it is full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2m_field_arithmetic_unit #(
   parameter int MAX_DEGREE = gfau_pkg::MAX_DEG_DFLT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data,     // field_degree
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,    // cmd
   input  wire logic [31:0] req_tdata,    // operand_a [15:0], operand_b [31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // result
   output logic             rsp_tuser     // divide_by_zero
);
   import gfau_pkg::*;

   gfau_op_type push_op, head_op;
   logic        push, pop, full, empty;

   gfau_front #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (full),
      .q_push     (push),
      .q_op       (push_op)
   );

   gfau_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty)
   );

   gfau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (empty),
      .q_head     (head_op),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

/* rtl/core/gfau_front.sv */
// ----------------------------------------------------------------------------
// gfau_front
// Degree register and request decode: turns each request into x * base^expo.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_front #(
   parameter int MAX_DEGREE = gfau_pkg::MAX_DEG_DFLT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [gfau_pkg::DEG_W-1:0] csr_data,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [1:0]                 req_tuser,   // cmd
   input  wire logic [31:0]                req_tdata,   // operand_a, operand_b
   input  wire logic                       q_full,
   output logic                            q_push,
   output gfau_pkg::gfau_op_type           q_op
);
   import gfau_pkg::*;

   localparam logic [DEG_W-1:0] MAX_M = DEG_W'(MAX_DEGREE);

   logic [DEG_W-1:0]  degree_ff, degree_in;
   logic [DEG_W-1:0]  m;
   logic [ELEM_W-1:0] mask, a, b, braw;
   gfau_cmd_type      cmd;

   assign csr_ready = 1'b1;
   assign degree_in = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
      end else if (csr_valid) begin
         degree_ff <= degree_in;
      end
   end

   always_comb begin
      if (degree_ff == '0) m = DEG_W'(1);
      else if (degree_ff > MAX_M) m = MAX_M;
      else m = degree_ff;
   end

   assign mask = ELEM_W'(((ELEM_W+1)'(1) << m) - (ELEM_W+1)'(1));
   assign cmd  = gfau_cmd_type'(req_tuser);
   assign braw = req_tdata[31:16];
   assign a    = req_tdata[15:0] & mask;
   assign b    = braw & mask;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_op      = '0;
      q_op.m    = m;
      q_op.base = b;
      case (cmd)
         CMD_ADD: begin
            q_op.x = a ^ b;                    // exponent 0: times one
         end
         CMD_MUL: begin
            q_op.x    = a;
            q_op.expo = ELEM_W'(1);
         end
         CMD_DIV: begin
            if (b == '0) begin
               q_op.dz = 1'b1;                 // x stays zero
            end else begin
               q_op.x    = a;
               q_op.expo = mask - ELEM_W'(1);  // inverse is b^(2^m-2)
            end
         end
         CMD_POW: begin
            q_op.x    = (a != '0) ? ELEM_W'(1) : '0;
            q_op.base = a;
            q_op.expo = braw;
         end
         default: begin
            q_op.x = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/gfau_queue.sv */
// ----------------------------------------------------------------------------
// gfau_queue
// Small request queue between decode and the exponent pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  gfau_pkg::gfau_op_type push_op,
   output logic                  full,
   input  wire logic             pop,
   output gfau_pkg::gfau_op_type head_op,
   output logic                  empty
);
   import gfau_pkg::*;

   gfau_op_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entry_ff[rptr_ff];

   assign wptr_in  = push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
   assign rptr_in  = pop  ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
   assign count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wptr_ff] <= push_op;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/core/gfau_back.sv */
// ----------------------------------------------------------------------------
// gfau_back
// Square-and-multiply pipeline, one exponent bit per stage, then x * power.
// ----------------------------------------------------------------------------
`default_nettype none

module gfau_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_empty,
   input  gfau_pkg::gfau_op_type            q_head,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [15:0]                      rsp_tdata,   // result
   output logic                             rsp_tuser    // divide_by_zero
);
   import gfau_pkg::*;

   gfau_stage_type    stg_ff  [ELEM_W+1];
   gfau_stage_type    stg_in  [ELEM_W+1];
   logic              vld_ff  [ELEM_W+1];
   logic              vld_in  [ELEM_W+1];
   logic [ELEM_W-1:0] res_ff, res_in;
   logic              dz_ff, dz_in;
   logic [DEG_W-1:0]  om_ff;
   logic              ovld_ff;
   logic              en;

   // whole pipeline moves together; output stage frees when taken
   assign en    = !ovld_ff || rsp_tready;
   assign q_pop = en && !q_empty;

   always_comb begin
      stg_in[0].m    = q_head.m;
      stg_in[0].x    = q_head.x;
      stg_in[0].base = q_head.base;
      stg_in[0].r    = ELEM_W'(1);
      stg_in[0].expo = q_head.expo;
      stg_in[0].dz   = q_head.dz;
      vld_in[0]      = !q_empty;
   end

   for (genvar k = 0; k < ELEM_W; k++) begin : g_exp
      always_comb begin
         stg_in[k+1]      = stg_ff[k];
         stg_in[k+1].base = gf_mul(stg_ff[k].base, stg_ff[k].base, stg_ff[k].m);
         if (stg_ff[k].expo[k]) begin
            stg_in[k+1].r = gf_mul(stg_ff[k].r, stg_ff[k].base, stg_ff[k].m);
         end
         vld_in[k+1] = vld_ff[k];
      end
   end

   for (genvar k = 0; k <= ELEM_W; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) stg_ff[k] <= stg_in[k];
      end
   end

   assign res_in = gf_mul(stg_ff[ELEM_W].x, stg_ff[ELEM_W].r, stg_ff[ELEM_W].m);
   assign dz_in  = stg_ff[ELEM_W].dz;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= vld_ff[ELEM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         dz_ff  <= dz_in;
         om_ff  <= stg_ff[ELEM_W].m;
      end
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = dz_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      ovld_ff && dz_ff |-> res_ff == '0)
      else $error("divide by zero with nonzero result");

   a_res_in_field: assert property (@(posedge clock) disable iff (reset)
      ovld_ff |-> (32'(res_ff) >> om_ff) == 32'd0)
      else $error("result outside the field");

   // held response stays put until taken
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      ovld_ff && !rsp_tready |=> ovld_ff && $stable(res_ff) && $stable(dz_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
